FILE: design/sbwfb_pkg.sv
// Package: shared constants, register layout tables and control types for the frame builder.
package sbwfb_pkg;

    localparam int NUM_REGS    = 12;
    localparam int SHADOW_SIZE = 40;
    localparam int ADDR_W      = 8;
    localparam int DATA_W      = 8;
    localparam int MEM_AW      = 6;
    localparam int REG_W       = 4;
    localparam int LEN_W       = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EVERY_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STB_SEL    = 2'd1;

    localparam logic [1:0] STB_SEL_QUIET = 2'd2;

    localparam logic [1:0] BEAT_HDR  = 2'd0;
    localparam logic [1:0] BEAT_DATA = 2'd1;
    localparam logic [1:0] BEAT_ERR  = 2'd2;

    localparam logic [MEM_AW-1:0] REG_BASE [NUM_REGS] = '{
        6'd0, 6'd2, 6'd4, 6'd10, 6'd16, 6'd22, 6'd26, 6'd29, 6'd33, 6'd35, 6'd37, 6'd38
    };
    localparam logic [MEM_AW-1:0] REG_END [NUM_REGS] = '{
        6'd1, 6'd3, 6'd9, 6'd15, 6'd21, 6'd25, 6'd28, 6'd32, 6'd34, 6'd36, 6'd37, 6'd39
    };
    localparam logic [LEN_W-1:0] REG_LEN_M1 [NUM_REGS] = '{
        3'd1, 3'd1, 3'd5, 3'd5, 3'd5, 3'd3, 3'd2, 3'd3, 3'd1, 3'd1, 3'd0, 3'd1
    };

    typedef struct packed {
        logic       accept;
        logic       load;
        logic [1:0] kind;
        logic       rd_en;
        logic       rd_first;
        logic       cnt_clr;
        logic       cnt_inc;
    } t_cmd;

    typedef struct packed {
        logic addr_err;
        logic need_frame;
        logic cnt_last;
        logic out_free;
    } t_sts;

    function automatic logic [REG_W-1:0] reg_of(input logic [MEM_AW-1:0] a);
        logic [REG_W-1:0] idx;
        idx = '0;
        for (int r = 1; r < NUM_REGS; r++) begin
            if (a >= REG_BASE[r]) begin
                idx = REG_W'(r);
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/sbwfb_wr_if.sv
// Interface: byte write channel (address and value).
interface sbwfb_wr_if;
    logic                               valid;
    logic                               ready;
    logic [sbwfb_pkg::ADDR_W-1:0]       byte_address;
    logic [sbwfb_pkg::DATA_W-1:0]       byte_value;

    modport source (output valid, output byte_address, output byte_value, input ready);
    modport sink   (input valid, input byte_address, input byte_value, output ready);
endinterface

FILE: design/sbwfb_frm_if.sv
// Interface: frame byte output channel.
interface sbwfb_frm_if;
    logic                               valid;
    logic                               ready;
    logic [sbwfb_pkg::DATA_W-1:0]       frame_byte;
    logic                               is_command;
    logic                               frame_last;
    logic                               strobe_pulse;
    logic                               address_error;

    modport source (output valid, output frame_byte, output is_command, output frame_last,
                    output strobe_pulse, output address_error, input ready);
    modport sink   (input valid, input frame_byte, input is_command, input frame_last,
                    input strobe_pulse, input address_error, output ready);
endinterface

FILE: design/shadowed_byte_write_frame_builder_top.sv
// Top level: byte write frame builder with shadow store.
//
//   channel  dir  handshake          beat contents
//   i_wr     in   valid/ready        byte_address, byte_value
//   o_frm    out  valid/ready        frame_byte, is_command, frame_last,
//                                    strobe_pulse, address_error
//   cfg      in   i_cfg_we only      i_cfg_idx, i_cfg_data
//
// A write that ends a frame is accepted and stored, then goes out one beat per cycle while
// o_frm is ready: header, then len data bytes read from the shadow RAM. A bad address
// sends one error beat; a silent write is only stored. The shadow RAM port sets the pace.
// Reset clears the shadow at once through per-byte valid flags; no sweep.
// A stall on o_frm holds the frame; i_wr stays not ready until the last beat is loaded.
module shadowed_byte_write_frame_builder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sbwfb_wr_if.sink                            i_wr,
    sbwfb_frm_if.source                         o_frm,
    input  logic                                i_cfg_we,
    input  logic [sbwfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbwfb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    sbwfb_pkg::t_cmd cmd;
    sbwfb_pkg::t_sts sts;

    sbwfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_wr.valid),
        .o_in_ready (i_wr.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbwfb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_byte_address  (i_wr.byte_address),
        .i_byte_value    (i_wr.byte_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_frm.ready),
        .o_out_valid     (o_frm.valid),
        .o_frame_byte    (o_frm.frame_byte),
        .o_is_command    (o_frm.is_command),
        .o_frame_last    (o_frm.frame_last),
        .o_strobe_pulse  (o_frm.strobe_pulse),
        .o_address_error (o_frm.address_error)
    );

endmodule

FILE: design/sbwfb_ctrl.sv
// Controller: sequences header, data and error beats of one write.
module sbwfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbwfb_pkg::t_sts   i_sts,
    output sbwfb_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ERR  = 2'd1;
    localparam logic [1:0] S_HDR  = 2'd2;
    localparam logic [1:0] S_DATA = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.kind     = sbwfb_pkg::BEAT_HDR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.addr_err) begin
                        n_state = S_ERR;
                    end else if (i_sts.need_frame) begin
                        n_state = S_HDR;
                    end
                end
            end
            S_ERR: begin
                o_cmd.kind = sbwfb_pkg::BEAT_ERR;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_HDR: begin
                o_cmd.kind = sbwfb_pkg::BEAT_HDR;
                if (i_sts.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_first = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.kind = sbwfb_pkg::BEAT_DATA;
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.cnt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/sbwfb_dp.sv
// Datapath: shadow store, register decode, config registers and output register.
module sbwfb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbwfb_pkg::t_cmd                     i_cmd,
    output sbwfb_pkg::t_sts                     o_sts,
    input  logic [sbwfb_pkg::ADDR_W-1:0]        i_byte_address,
    input  logic [sbwfb_pkg::DATA_W-1:0]        i_byte_value,
    input  logic                                i_cfg_we,
    input  logic [sbwfb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbwfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sbwfb_pkg::DATA_W-1:0]        o_frame_byte,
    output logic                                o_is_command,
    output logic                                o_frame_last,
    output logic                                o_strobe_pulse,
    output logic                                o_address_error
);

    localparam int AW = sbwfb_pkg::MEM_AW;
    localparam int DW = sbwfb_pkg::DATA_W;

    logic [DW-1:0]                      r_mem [sbwfb_pkg::SHADOW_SIZE];
    logic [sbwfb_pkg::SHADOW_SIZE-1:0]  r_vld;
    logic [DW-1:0]                      r_rd_data;
    logic                               r_rd_vld;

    logic                               r_every_byte;
    logic [1:0]                         r_stb_sel;

    logic [sbwfb_pkg::REG_W-1:0]        r_reg;
    logic [AW-1:0]                      r_base;
    logic [sbwfb_pkg::LEN_W-1:0]        r_len_m1;
    logic [sbwfb_pkg::LEN_W-1:0]        r_cnt;

    logic                               r_o_valid;
    logic [DW-1:0]                      r_o_byte;
    logic                               r_o_cmd;
    logic                               r_o_last;
    logic                               r_o_stb;
    logic                               r_o_err;

    logic [DW-1:0]                      n_o_byte;
    logic                               n_o_cmd;
    logic                               n_o_last;
    logic                               n_o_stb;
    logic                               n_o_err;

    logic [AW-1:0]                      in_a;
    logic                               in_range;
    logic [sbwfb_pkg::REG_W-1:0]        in_reg;
    logic [sbwfb_pkg::LEN_W-1:0]        rd_off;
    logic [AW-1:0]                      rd_addr;
    logic                               cnt_last;
    logic [DW-1:0]                      data_byte;

    assign in_a     = i_byte_address[AW-1:0];
    assign in_range = i_byte_address < sbwfb_pkg::ADDR_W'(sbwfb_pkg::SHADOW_SIZE);
    assign in_reg   = sbwfb_pkg::reg_of(in_a);
    assign cnt_last = (r_cnt == r_len_m1);
    assign rd_off   = i_cmd.rd_first ? '0 : r_cnt + 1'b1;
    assign rd_addr  = r_base + AW'(rd_off);
    assign data_byte = r_rd_vld ? r_rd_data : '0;

    assign o_sts.addr_err   = !in_range;
    assign o_sts.need_frame = r_every_byte || (in_a == sbwfb_pkg::REG_END[in_reg]);
    assign o_sts.cnt_last   = cnt_last;
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    always_comb begin
        n_o_byte = '0;
        n_o_cmd  = 1'b0;
        n_o_last = 1'b0;
        n_o_stb  = 1'b0;
        n_o_err  = 1'b0;
        case (i_cmd.kind)
            sbwfb_pkg::BEAT_HDR: begin
                n_o_byte = DW'(r_reg);
                n_o_cmd  = 1'b1;
            end
            sbwfb_pkg::BEAT_DATA: begin
                n_o_byte = data_byte;
                n_o_last = cnt_last;
                n_o_stb  = cnt_last && (r_stb_sel != sbwfb_pkg::STB_SEL_QUIET);
            end
            sbwfb_pkg::BEAT_ERR: begin
                n_o_last = 1'b1;
                n_o_err  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && in_range) begin
            r_mem[in_a] <= i_byte_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_every_byte <= 1'b1;
            r_stb_sel    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.accept && in_range) begin
                r_vld[in_a] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbwfb_pkg::CFG_EVERY_BYTE: r_every_byte <= i_cfg_data[0];
                    sbwfb_pkg::CFG_STB_SEL:    r_stb_sel    <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_reg    <= in_reg;
            r_base   <= sbwfb_pkg::REG_BASE[in_reg];
            r_len_m1 <= sbwfb_pkg::REG_LEN_M1[in_reg];
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.load) begin
            r_o_byte <= n_o_byte;
            r_o_cmd  <= n_o_cmd;
            r_o_last <= n_o_last;
            r_o_stb  <= n_o_stb;
            r_o_err  <= n_o_err;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_frame_byte    = r_o_byte;
    assign o_is_command    = r_o_cmd;
    assign o_frame_last    = r_o_last;
    assign o_strobe_pulse  = r_o_stb;
    assign o_address_error = r_o_err;

endmodule

FILE: design/sbwfb_chk.sv
// Checker: port-level assertions for the frame builder, bound to the top level.
module sbwfb_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic [sbwfb_pkg::ADDR_W-1:0]     i_byte_address,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [sbwfb_pkg::DATA_W-1:0]     i_frame_byte,
    input logic                             i_is_command,
    input logic                             i_frame_last,
    input logic                             i_strobe_pulse,
    input logic                             i_address_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_address_error |->
            i_frame_last && !i_is_command && !i_strobe_pulse && (i_frame_byte == '0))
        else $error("malformed error beat");

    a_strobe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_strobe_pulse |-> i_frame_last && !i_address_error)
        else $error("strobe off the last frame byte");

    a_hdr_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_command |->
            !i_frame_last && !i_address_error
            && (i_frame_byte < sbwfb_pkg::DATA_W'(sbwfb_pkg::NUM_REGS)))
        else $error("malformed header beat");

    a_err_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready
            && (i_byte_address >= sbwfb_pkg::ADDR_W'(sbwfb_pkg::SHADOW_SIZE))
        |=> !i_in_ready)
        else $error("input taken while error beat pending");

endmodule

bind shadowed_byte_write_frame_builder_top sbwfb_chk u_sbwfb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_wr.valid),
    .i_in_ready      (i_wr.ready),
    .i_byte_address  (i_wr.byte_address),
    .i_out_valid     (o_frm.valid),
    .i_out_ready     (o_frm.ready),
    .i_frame_byte    (o_frm.frame_byte),
    .i_is_command    (o_frm.is_command),
    .i_frame_last    (o_frm.frame_last),
    .i_strobe_pulse  (o_frm.strobe_pulse),
    .i_address_error (o_frm.address_error)
);
